@@ hw/rtl/ympf_pkg.sv @@
// ----------------------------------------------------------------------------
// ympf_pkg
// Shared types, codes and the CRC-16 byte update for the YMODEM framer.
// ----------------------------------------------------------------------------
package ympf_pkg;

   localparam int FRAME_BYTES = 1024;
   localparam int POS_W       = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int MAX_RESULTS = 6;
   localparam int CNT_W       = 3;
   localparam int CSR_IDX_W   = 4;

   localparam logic [1:0] REQ_DATA    = 2'd0;
   localparam logic [1:0] REQ_END     = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CRC_POLY   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_INIT   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_CODE = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_CODE   = 4'd3;

   localparam logic [15:0] CRC_POLY_RESET   = 16'h1021;
   localparam logic [15:0] CRC_INIT_RESET   = 16'h0000;
   localparam logic [7:0]  START_CODE_RESET = 8'h02;
   localparam logic [7:0]  END_CODE_RESET   = 8'h04;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       frame_done;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] crc_poly;
      logic [15:0] crc_init;
      logic [7:0]  start_code;
      logic [7:0]  end_code;
   } cfg_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                              input logic [7:0]  b,
                                              input logic [15:0] poly);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ poly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/ympf_csr.sv @@
// ----------------------------------------------------------------------------
// ympf_csr
// Configuration registers of the framer, written through a valid/ready port.
// ----------------------------------------------------------------------------
module ympf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ympf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [15:0]                      csr_wdata,
   output ympf_pkg::cfg_type                cfg
);
   import ympf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CRC_POLY:   cfg_in.crc_poly   = csr_wdata;
            CSR_CRC_INIT:   cfg_in.crc_init   = csr_wdata;
            CSR_START_CODE: cfg_in.start_code = csr_wdata[7:0];
            CSR_END_CODE:   cfg_in.end_code   = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_poly   <= CRC_POLY_RESET;
         cfg_ff.crc_init   <= CRC_INIT_RESET;
         cfg_ff.start_code <= START_CODE_RESET;
         cfg_ff.end_code   <= END_CODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/ymodem_packet_framer_crc16.sv @@
// ----------------------------------------------------------------------------
// ymodem_packet_framer_crc16
// Frames payload bytes into a YMODEM byte stream with a CRC-16 trailer.
// ----------------------------------------------------------------------------
// Each request transaction is decoded into up to six stream bytes held in
// a result shift buffer that drains one byte per cycle while rsp_ready is
// high. Payload bytes inside a frame yield one byte each and so stream at
// one transaction per cycle; the first byte of a frame yields four (header
// plus byte), the last byte three (byte plus CRC), and a one-byte frame six.
// End requests yield one byte, restart requests and unused codes produce no
// bytes. The next request is taken while the last buffered byte leaves.
module ymodem_packet_framer_crc16 (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ympf_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ympf_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ympf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [15:0]                      csr_wdata
);
   import ympf_pkg::*;

   cfg_type cfg;

   ympf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rsp_payload_type buf_ff [MAX_RESULTS];
   rsp_payload_type buf_in [MAX_RESULTS];
   rsp_payload_type list   [MAX_RESULTS];
   logic [CNT_W-1:0] cnt_ff, cnt_in, list_n;
   logic [15:0]      crc_ff, crc_in, crc_next;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       seq_ff, seq_in;
   logic [POS_W:0]   pos_plus;
   logic             accept, pop, hdr, tail;

   assign rsp_valid   = (cnt_ff != '0);
   assign rsp_payload = buf_ff[0];
   assign pop         = rsp_valid && rsp_ready;
   assign req_ready   = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && rsp_ready);
   assign accept      = req_valid && req_ready;

   assign hdr      = (pos_ff == '0);
   assign pos_plus = {1'b0, pos_ff} + (POS_W+1)'(1);
   assign tail     = (pos_plus >= (POS_W+1)'(FRAME_BYTES));
   assign crc_next = crc_update(hdr ? cfg.crc_init : crc_ff, req_payload.data_byte,
                                cfg.crc_poly);

   always_comb begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         list[i] = '0;
      end
      list_n = '0;
      crc_in = crc_ff;
      pos_in = pos_ff;
      seq_in = seq_ff;
      case (req_payload.req_type)
         REQ_DATA: begin
            crc_in = crc_next;
            pos_in = tail ? '0 : pos_plus[POS_W-1:0];
            if (tail) begin
               seq_in = seq_ff + 8'd1;
            end
            if (hdr) begin
               list[0].out_byte = cfg.start_code;
               list[1].out_byte = seq_ff;
               list[2].out_byte = ~seq_ff;
               list[3].out_byte = req_payload.data_byte;
               if (tail) begin
                  list[4].out_byte   = crc_next[15:8];
                  list[5].out_byte   = crc_next[7:0];
                  list[5].frame_done = 1'b1;
                  list_n             = CNT_W'(6);
               end else begin
                  list_n = CNT_W'(4);
               end
            end else begin
               list[0].out_byte = req_payload.data_byte;
               if (tail) begin
                  list[1].out_byte   = crc_next[15:8];
                  list[2].out_byte   = crc_next[7:0];
                  list[2].frame_done = 1'b1;
                  list_n             = CNT_W'(3);
               end else begin
                  list_n = CNT_W'(1);
               end
            end
         end
         REQ_END: begin
            pos_in             = '0;
            seq_in             = seq_ff + 8'd1;
            list[0].out_byte   = cfg.end_code;
            list[0].frame_done = 1'b1;
            list_n             = CNT_W'(1);
         end
         REQ_RESTART: begin
            seq_in = '0;
         end
         default: begin
         end
      endcase
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (CNT_W'(i + 1) == list_n) begin
            list[i].last_of_run = 1'b1;
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         buf_in[i] = buf_ff[i];
      end
      if (accept) begin
         cnt_in = list_n;
         for (int i = 0; i < MAX_RESULTS; i++) begin
            buf_in[i] = list[i];
         end
      end else if (pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            buf_in[i] = buf_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         crc_ff <= '0;
         pos_ff <= '0;
         seq_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (accept) begin
            crc_ff <= crc_in;
            pos_ff <= pos_in;
            seq_ff <= seq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         buf_ff[i] <= buf_in[i];
      end
   end

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("result count out of range");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, pos_ff} < (POS_W+1)'(FRAME_BYTES))
      else $error("byte position beyond frame");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_done |-> rsp_payload.last_of_run)
      else $error("frame_done without last_of_run");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      pop && !accept |=> cnt_ff == $past(cnt_ff) - CNT_W'(1))
      else $error("result buffer did not drain by one");

   a_last_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last_of_run |-> cnt_ff == CNT_W'(1))
      else $error("last_of_run before end of buffered run");
`endif

endmodule
